### sv/hpbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpbp_pkg
// Shared sizes, codes, types and helper functions of the hashed perceptron
// branch predictor.
// ----------------------------------------------------------------------------
package hpbp_pkg;

    // table geometry
    localparam int INDEX_BITS  = 10;
    localparam int RECENT_LEN  = 20;
    localparam int MIDDLE_LEN  = 16;
    localparam int FAR_LEN     = 29;
    localparam int HISTORY_LEN = 128;

    localparam int FAR_BITS  = INDEX_BITS - 1;
    localparam int NEAR_LEN  = RECENT_LEN + MIDDLE_LEN;
    localparam int USED_LEN  = NEAR_LEN + FAR_LEN;
    localparam int LIMIT_RAW = HISTORY_LEN - USED_LEN;
    localparam int FLIGHT_LIMIT = (LIMIT_RAW < 127) ? LIMIT_RAW : 127;
    localparam int FLIGHT_W  = $clog2(FLIGHT_LIMIT + 1);
    localparam int QA_BITS   = (FLIGHT_LIMIT > 1) ? $clog2(FLIGHT_LIMIT) : 1;

    // weights and sums
    localparam int W_BITS = 7;
    localparam logic signed [W_BITS-1:0] W_MAX = 7'sd63;
    localparam logic signed [W_BITS-1:0] W_MIN = -7'sd64;
    localparam int SUM_W  = 14;
    localparam int GRP    = 8;
    localparam int NGRP   = (USED_LEN + GRP - 1) / GRP;

    // threshold adaptation
    localparam int THR_W = 12;
    localparam logic [THR_W-1:0] THR_RESET = 12'd107;
    localparam logic [THR_W-1:0] THR_MAX   = 12'd4095;
    localparam int TC_W = 7;
    localparam logic signed [TC_W-1:0] TC_LIMIT = 7'sd63;

    // stream payload widths
    localparam int IN_W  = 40;
    localparam int OUT_W = 24;

    // commands and status codes
    localparam logic CMD_FETCH  = 1'b0;
    localparam logic CMD_RETIRE = 1'b1;
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // what an in-flight branch keeps for its later training
    typedef struct packed {
        logic                                   pred;
        logic                                   mark;
        logic [USED_LEN-1:0]                    outc;
        logic [FAR_LEN-1:0][FAR_BITS-1:0]       far_hash;
        logic [NEAR_LEN-1:0][INDEX_BITS-1:0]    near_hash;
    } flight_t;

    localparam int FLIGHT_BITS = $bits(flight_t);

    // address fold for the full-size tables
    function automatic logic [INDEX_BITS-1:0] hash_near(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> INDEX_BITS);
        return y[INDEX_BITS-1:0];
    endfunction

    // address fold for the half-size table
    function automatic logic [FAR_BITS-1:0] hash_far(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> FAR_BITS);
        return y[FAR_BITS-1:0];
    endfunction

    // saturating step of one weight
    function automatic logic [W_BITS-1:0] nudge(input logic [W_BITS-1:0] w,
                                                 input logic up);
        logic signed [W_BITS-1:0] s;
        s = $signed(w);
        if (up)
        begin
            return (s == W_MAX) ? w : w + 1'b1;
        end
        return (s == W_MIN) ? w : w - 1'b1;
    endfunction

endpackage
`default_nettype wire

### sv/hpbp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpbp_ram
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module hpbp_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 7
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### sv/hashed_perceptron_branch_predictor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_perceptron_branch_predictor_unit
// Hashed piecewise-linear perceptron branch predictor with banked weight
// memories, an in-flight queue for training and an adaptive threshold.
// ----------------------------------------------------------------------------
// After reset the unit zeroes its weight memories, one weight row at a time
// with all banks in parallel, and holds s_tready low meanwhile; threshold
// writes are taken at any time. One transaction is handled at a time: a
// fetch passes through a weight memory read, a two-level registered adder
// tree, the history update and the output load; a retire passes through an
// in-flight queue read, a weight read, the write-back of the nudged weights
// and the output load. Refused fetches and retires with nothing in flight go
// straight to the output load. A result waits in the output register while
// the next transaction is already accepted.
module hashed_perceptron_branch_predictor_unit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // threshold register
    input  wire logic                     cfg_we,
    input  wire logic [11:0]              cfg_wdata,
    // input stream
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [39:0]              s_tdata,  // pc[31:0], taken[32], zero pad
    input  wire logic                     s_tuser,  // command
    // result stream
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [23:0]                   m_tdata   // predict_taken[0],
                                                    // weight_sum[14:1],
                                                    // low_confidence[15],
                                                    // mispredicted[16],
                                                    // trained[17], status[19:18],
                                                    // zero pad
);
    import hpbp_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_F_RD, ST_F_ADD, ST_F_TOT, ST_F_END,
        ST_R_Q, ST_R_RD, ST_R_WR, ST_OUT
    } state_t;

    state_t                        state_reg;
    logic                          cmd_reg;
    logic [31:0]                   pc_reg;
    logic                          tk_reg;
    logic [USED_LEN-1:0][31:0]     path_reg;
    logic [USED_LEN-1:0]           outc_reg;
    logic [FLIGHT_W-1:0]           in_flight_reg;
    logic [QA_BITS-1:0]            wr_ptr_reg;
    logic [QA_BITS-1:0]            rd_ptr_reg;
    logic [THR_W-1:0]              thr_reg;
    logic signed [TC_W-1:0]        tc_reg;
    logic [INDEX_BITS-1:0]         clr_cnt_reg;
    logic signed [SUM_W-1:0]       grp_reg [NGRP];
    logic signed [SUM_W-1:0]       sum_reg;
    logic [OUT_W-1:0]              res_reg;
    logic                          out_valid_reg;
    logic [OUT_W-1:0]              out_data_reg;

    logic                          clearing;
    logic                          s_fire;
    flight_t                       q_wdata;
    logic [FLIGHT_BITS-1:0]        q_rdata;
    flight_t                       entry;
    logic                          q_we;

    logic [NEAR_LEN-1:0][INDEX_BITS-1:0] near_addr;
    logic [FAR_LEN-1:0][FAR_BITS-1:0]    far_addr;
    logic [USED_LEN-1:0]                 outc_sel;

    logic [W_BITS-1:0] rt_rd [RECENT_LEN];
    logic [W_BITS-1:0] rn_rd [RECENT_LEN];
    logic [W_BITS-1:0] md_rd [MIDDLE_LEN];
    logic [W_BITS-1:0] fr_rd [FAR_LEN];
    logic [RECENT_LEN-1:0] rt_we;
    logic [RECENT_LEN-1:0] rn_we;

    logic signed [SUM_W-1:0] term [USED_LEN];
    logic signed [SUM_W-1:0] grp_next [NGRP];
    logic signed [SUM_W-1:0] sum_next;

    logic                    miss;
    logic                    train;
    logic                    train_wr;
    logic                    pred_now;
    logic                    low_now;
    logic signed [SUM_W:0]   sum_x;
    logic signed [SUM_W:0]   thr_x;
    logic                    out_free;

    assign clearing = (state_reg == ST_CLEAR);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign entry    = flight_t'(q_rdata);

    // fetch and retire decisions
    assign pred_now = (sum_reg >= 0);
    assign sum_x    = {sum_reg[SUM_W-1], sum_reg};
    assign thr_x    = $signed({{(SUM_W + 1 - THR_W){1'b0}}, thr_reg});
    assign low_now  = (sum_x < thr_x) && (sum_x > -thr_x);
    assign miss     = (entry.pred != tk_reg);
    assign train    = miss || entry.mark;
    assign train_wr = (state_reg == ST_R_WR) && train;

    // weight row addresses for fetch (history taps) or retire (queued hashes)
    always_comb
    begin
        for (int j = 0; j < NEAR_LEN; j++)
        begin
            if (cmd_reg == CMD_FETCH)
            begin
                near_addr[j] = hash_near(pc_reg) ^ hash_near(path_reg[j]);
            end
            else
            begin
                near_addr[j] = hash_near(pc_reg) ^ entry.near_hash[j];
            end
        end
        for (int k = 0; k < FAR_LEN; k++)
        begin
            if (cmd_reg == CMD_FETCH)
            begin
                far_addr[k] = hash_far(pc_reg) ^ hash_far(path_reg[NEAR_LEN + k]);
            end
            else
            begin
                far_addr[k] = hash_far(pc_reg) ^ entry.far_hash[k];
            end
        end
        outc_sel = (cmd_reg == CMD_FETCH) ? outc_reg : entry.outc;
    end

    // weight banks: a taken/not-taken pair per recent position, one per other position
    for (genvar j = 0; j < RECENT_LEN; j++)
    begin : g_recent
        logic [INDEX_BITS-1:0] addr;
        assign addr     = clearing ? clr_cnt_reg : near_addr[j];
        assign rt_we[j] = clearing || (train_wr && outc_sel[j]);
        assign rn_we[j] = clearing || (train_wr && !outc_sel[j]);

        hpbp_ram #(.ADDR_BITS(INDEX_BITS), .DATA_BITS(W_BITS)) u_taken (
            .clk   (clk),
            .we    (rt_we[j]),
            .waddr (addr),
            .wdata (clearing ? '0 : nudge(rt_rd[j], tk_reg)),
            .raddr (addr),
            .rdata (rt_rd[j])
        );

        hpbp_ram #(.ADDR_BITS(INDEX_BITS), .DATA_BITS(W_BITS)) u_not_taken (
            .clk   (clk),
            .we    (rn_we[j]),
            .waddr (addr),
            .wdata (clearing ? '0 : nudge(rn_rd[j], tk_reg)),
            .raddr (addr),
            .rdata (rn_rd[j])
        );
    end

    for (genvar k = 0; k < MIDDLE_LEN; k++)
    begin : g_middle
        logic [INDEX_BITS-1:0] addr;
        assign addr = clearing ? clr_cnt_reg : near_addr[RECENT_LEN + k];

        hpbp_ram #(.ADDR_BITS(INDEX_BITS), .DATA_BITS(W_BITS)) u_middle (
            .clk   (clk),
            .we    (clearing || train_wr),
            .waddr (addr),
            .wdata (clearing ? '0
                             : nudge(md_rd[k], outc_sel[RECENT_LEN + k] == tk_reg)),
            .raddr (addr),
            .rdata (md_rd[k])
        );
    end

    for (genvar k = 0; k < FAR_LEN; k++)
    begin : g_far
        logic [FAR_BITS-1:0] addr;
        assign addr = clearing ? clr_cnt_reg[FAR_BITS-1:0] : far_addr[k];

        hpbp_ram #(.ADDR_BITS(FAR_BITS), .DATA_BITS(W_BITS)) u_far (
            .clk   (clk),
            .we    (clearing || train_wr),
            .waddr (addr),
            .wdata (clearing ? '0
                             : nudge(fr_rd[k], outc_sel[NEAR_LEN + k] == tk_reg)),
            .raddr (addr),
            .rdata (fr_rd[k])
        );
    end

    // queue entry for the branch being fetched
    always_comb
    begin
        for (int j = 0; j < NEAR_LEN; j++)
        begin
            q_wdata.near_hash[j] = hash_near(path_reg[j]);
        end
        for (int k = 0; k < FAR_LEN; k++)
        begin
            q_wdata.far_hash[k] = hash_far(path_reg[NEAR_LEN + k]);
        end
        q_wdata.outc = outc_reg;
        q_wdata.pred = pred_now;
        q_wdata.mark = low_now;
    end

    assign q_we = (state_reg == ST_F_END);

    // in-flight queue
    hpbp_ram #(.ADDR_BITS(QA_BITS), .DATA_BITS(FLIGHT_BITS)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (wr_ptr_reg),
        .wdata (q_wdata),
        .raddr (rd_ptr_reg),
        .rdata (q_rdata)
    );

    // signed contribution of each position
    always_comb
    begin
        for (int j = 0; j < RECENT_LEN; j++)
        begin
            term[j] = outc_reg[j]
                ? {{(SUM_W - W_BITS){rt_rd[j][W_BITS-1]}}, rt_rd[j]}
                : {{(SUM_W - W_BITS){rn_rd[j][W_BITS-1]}}, rn_rd[j]};
        end
        for (int k = 0; k < MIDDLE_LEN; k++)
        begin
            term[RECENT_LEN + k] = outc_reg[RECENT_LEN + k]
                ?  $signed({{(SUM_W - W_BITS){md_rd[k][W_BITS-1]}}, md_rd[k]})
                : -$signed({{(SUM_W - W_BITS){md_rd[k][W_BITS-1]}}, md_rd[k]});
        end
        for (int k = 0; k < FAR_LEN; k++)
        begin
            term[NEAR_LEN + k] = outc_reg[NEAR_LEN + k]
                ?  $signed({{(SUM_W - W_BITS){fr_rd[k][W_BITS-1]}}, fr_rd[k]})
                : -$signed({{(SUM_W - W_BITS){fr_rd[k][W_BITS-1]}}, fr_rd[k]});
        end
    end

    // first adder level: groups of eight
    always_comb
    begin
        int p;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int i = 0; i < GRP; i++)
            begin
                p = g * GRP + i;
                if (p < USED_LEN)
                begin
                    grp_next[g] = grp_next[g] + term[p];
                end
            end
        end
    end

    // second adder level
    always_comb
    begin
        sum_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            sum_next = sum_next + grp_reg[g];
        end
    end

    // control, history, threshold and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cmd_reg       <= CMD_FETCH;
            pc_reg        <= '0;
            tk_reg        <= 1'b0;
            path_reg      <= '0;
            outc_reg      <= '0;
            in_flight_reg <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            thr_reg       <= THR_RESET;
            tc_reg        <= '0;
            clr_cnt_reg   <= '0;
            for (int g = 0; g < NGRP; g++)
            begin
                grp_reg[g] <= '0;
            end
            sum_reg       <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // output register drains independently
            if (out_valid_reg && m_tready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (&clr_cnt_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        cmd_reg <= s_tuser;
                        pc_reg  <= s_tdata[31:0];
                        tk_reg  <= s_tdata[32];
                        res_reg <= '0;
                        if (s_tuser == CMD_FETCH)
                        begin
                            if (in_flight_reg >= FLIGHT_W'(FLIGHT_LIMIT))
                            begin
                                res_reg[19:18] <= STATUS_FULL;
                                state_reg      <= ST_OUT;
                            end
                            else
                            begin
                                state_reg <= ST_F_RD;
                            end
                        end
                        else
                        begin
                            if (in_flight_reg == '0)
                            begin
                                res_reg[19:18] <= STATUS_EMPTY;
                                state_reg      <= ST_OUT;
                            end
                            else
                            begin
                                state_reg <= ST_R_Q;
                            end
                        end
                    end
                end

                ST_F_RD:
                begin
                    state_reg <= ST_F_ADD;
                end

                ST_F_ADD:
                begin
                    for (int g = 0; g < NGRP; g++)
                    begin
                        grp_reg[g] <= grp_next[g];
                    end
                    state_reg <= ST_F_TOT;
                end

                ST_F_TOT:
                begin
                    sum_reg   <= sum_next;
                    state_reg <= ST_F_END;
                end

                ST_F_END:
                begin
                    // shift the history and record the prediction
                    path_reg      <= {path_reg[USED_LEN-2:0], pc_reg};
                    outc_reg      <= {outc_reg[USED_LEN-2:0], tk_reg};
                    wr_ptr_reg    <= wr_ptr_reg + 1'b1;
                    in_flight_reg <= in_flight_reg + 1'b1;
                    res_reg[0]    <= pred_now;
                    res_reg[14:1] <= sum_reg;
                    res_reg[15]   <= low_now;
                    state_reg     <= ST_OUT;
                end

                ST_R_Q:
                begin
                    state_reg <= ST_R_RD;
                end

                ST_R_RD:
                begin
                    state_reg <= ST_R_WR;
                end

                ST_R_WR:
                begin
                    // threshold adaptation, unless a threshold write lands now
                    if (!cfg_we)
                    begin
                        if (miss)
                        begin
                            if (tc_reg + 7'sd1 >= TC_LIMIT)
                            begin
                                tc_reg <= '0;
                                if (thr_reg != THR_MAX)
                                begin
                                    thr_reg <= thr_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                tc_reg <= tc_reg + 7'sd1;
                            end
                        end
                        else if (entry.mark)
                        begin
                            if (tc_reg - 7'sd1 <= -TC_LIMIT)
                            begin
                                tc_reg <= '0;
                                if (thr_reg != '0)
                                begin
                                    thr_reg <= thr_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                tc_reg <= tc_reg - 7'sd1;
                            end
                        end
                    end
                    rd_ptr_reg    <= rd_ptr_reg + 1'b1;
                    in_flight_reg <= in_flight_reg - 1'b1;
                    res_reg[16]   <= miss;
                    res_reg[17]   <= train;
                    state_reg     <= ST_OUT;
                end

                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // threshold write takes priority
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
                tc_reg  <= '0;
            end
        end
    end

    // in-flight count stays within the queue limit
    assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg <= FLIGHT_W'(FLIGHT_LIMIT))
        else $error("in-flight count above limit");

    // queue pointers agree with the in-flight count
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == in_flight_reg[QA_BITS-1:0])
        else $error("queue pointers out of step with in-flight count");

    // a recent bank pair never writes both tables in one cycle outside clearing
    assert property (@(posedge clk) disable iff (!rst_n)
        !clearing |-> ((rt_we & rn_we) == '0))
        else $error("taken and not-taken tables written together");

    // the in-flight count moves by at most one per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_flight_reg == $past(in_flight_reg))
        || (in_flight_reg == $past(in_flight_reg) + 1'b1)
        || (in_flight_reg + 1'b1 == $past(in_flight_reg)))
        else $error("in-flight count jumped");

endmodule
`default_nettype wire
